### src/kcpv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcpv_pkg
// Shared types and constants for the KCP packet validator.
// ----------------------------------------------------------------------------
package kcpv_pkg;

    localparam int HEADER_BYTES = 24;
    localparam int HDR_IDX_W    = 5;
    localparam int COUNT_W      = 11;
    localparam int PUSH_W       = 7;

    // header byte positions
    localparam logic [HDR_IDX_W-1:0] HDR_CONV_END = 5'd3;
    localparam logic [HDR_IDX_W-1:0] HDR_CMD      = 5'd4;
    localparam logic [HDR_IDX_W-1:0] HDR_FRG      = 5'd5;
    localparam logic [HDR_IDX_W-1:0] HDR_WND_LO   = 5'd6;
    localparam logic [HDR_IDX_W-1:0] HDR_WND_HI   = 5'd7;
    localparam logic [HDR_IDX_W-1:0] HDR_LAST     = 5'(HEADER_BYTES - 1);

    // segment commands
    localparam logic [7:0] CMD_PUSH       = 8'd81;
    localparam logic [7:0] CMD_FIRST_CTRL = 8'd82;
    localparam logic [7:0] CMD_LAST_CTRL  = 8'd84;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [PUSH_W-1:0]  PUSH_MAX  = '1;

    // configuration register indexes
    localparam logic [2:0] REG_CONV_ID      = 3'd0;
    localparam logic [2:0] REG_MAX_WINDOW   = 3'd1;
    localparam logic [2:0] REG_MAX_PAYLOAD  = 3'd2;
    localparam logic [2:0] REG_MAX_PACKET   = 3'd3;
    localparam logic [2:0] REG_MAX_PENDING  = 3'd4;

    // reset values
    localparam logic [15:0]        RST_MAX_WINDOW  = 16'd128;
    localparam logic [15:0]        RST_MAX_PAYLOAD = 16'd1024;
    localparam logic [COUNT_W-1:0] RST_MAX_PACKET  = 11'd1168;
    localparam logic [15:0]        RST_MAX_PENDING = 16'd256;

    typedef struct packed {
        logic [31:0]        conversation_id;
        logic [15:0]        max_peer_window;
        logic [15:0]        max_payload_bytes;
        logic [COUNT_W-1:0] max_packet_bytes;
        logic [15:0]        ack_limit;
    } cfg_t;

    typedef struct packed {
        logic              accept;
        logic [PUSH_W-1:0] push_count;
    } verdict_t;

endpackage

### src/kcpv_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcpv_parser
// Per-byte segment walker: tracks header position, payload skip, rule
// violations and push count; gives the packet verdict on the last byte.
// ----------------------------------------------------------------------------
module kcpv_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  kcpv_pkg::cfg_t    cfg,
    input  logic              step,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    input  logic              channel_failed,
    input  logic [15:0]       pending_acks,
    output kcpv_pkg::verdict_t verdict
);
    import kcpv_pkg::*;

    logic [COUNT_W-1:0]   byte_count_reg,   byte_count_next;
    logic [HDR_IDX_W-1:0] header_index_reg, header_index_next;
    logic [31:0]          field_shift_reg,  field_shift_next;
    logic [7:0]           seg_command_reg,  seg_command_next;
    logic [15:0]          seg_window_reg,   seg_window_next;
    logic [15:0]          payload_left_reg, payload_left_next;
    logic                 in_payload_reg,   in_payload_next;
    logic [PUSH_W-1:0]    pushes_seen_reg,  pushes_seen_next;
    logic                 bad_packet_reg,   bad_packet_next;

    logic [COUNT_W:0]     count_inc;
    logic [31:0]          shifted;
    logic [16:0]          pending_sum;
    logic                 ok;

    always_comb
    begin
        byte_count_next   = byte_count_reg;
        header_index_next = header_index_reg;
        field_shift_next  = field_shift_reg;
        seg_command_next  = seg_command_reg;
        seg_window_next   = seg_window_reg;
        payload_left_next = payload_left_reg;
        in_payload_next   = in_payload_reg;
        pushes_seen_next  = pushes_seen_reg;
        bad_packet_next   = bad_packet_reg;

        count_inc = {1'b0, byte_count_reg} + 1'b1;
        shifted   = {data_byte, field_shift_reg[31:8]};

        if (count_inc > {1'b0, cfg.max_packet_bytes})
            bad_packet_next = 1'b1;
        byte_count_next = count_inc[COUNT_W] ? COUNT_MAX : count_inc[COUNT_W-1:0];

        if (in_payload_reg)
        begin
            if (payload_left_reg != '0)
                payload_left_next = payload_left_reg - 1'b1;
            if (payload_left_next == '0)
                in_payload_next = 1'b0;
        end
        else
        begin
            field_shift_next = shifted;
            case (header_index_reg)
                HDR_CONV_END:
                begin
                    if (shifted != cfg.conversation_id)
                        bad_packet_next = 1'b1;
                end
                HDR_CMD:    seg_command_next = data_byte;
                HDR_FRG:
                begin
                    if (data_byte != 8'd0)
                        bad_packet_next = 1'b1;
                end
                HDR_WND_LO: seg_window_next = {8'd0, data_byte};
                HDR_WND_HI:
                begin
                    seg_window_next = {data_byte, seg_window_reg[7:0]};
                    if (seg_window_next > cfg.max_peer_window)
                        bad_packet_next = 1'b1;
                end
                default: ;
            endcase

            if (header_index_reg != HDR_LAST)
                header_index_next = header_index_reg + 1'b1;
            else
            begin
                // shifted now holds the length field
                if (seg_command_reg == CMD_PUSH)
                begin
                    if (shifted == '0 || shifted > {16'd0, cfg.max_payload_bytes})
                        bad_packet_next = 1'b1;
                    if (pushes_seen_reg != PUSH_MAX)
                        pushes_seen_next = pushes_seen_reg + 1'b1;
                end
                else if (!(seg_command_reg inside {[CMD_FIRST_CTRL:CMD_LAST_CTRL]})
                         || shifted != '0)
                begin
                    bad_packet_next = 1'b1;
                end
                header_index_next = '0;
                if (shifted != '0)
                begin
                    payload_left_next = (shifted[31:16] != '0) ? 16'hFFFF : shifted[15:0];
                    in_payload_next   = 1'b1;
                end
            end
        end

        pending_sum = {1'b0, pending_acks} + {10'd0, pushes_seen_next};
        ok = !bad_packet_next && !channel_failed && !in_payload_next
             && header_index_next == '0 && pending_sum <= {1'b0, cfg.ack_limit};

        verdict.accept     = ok;
        verdict.push_count = ok ? pushes_seen_next : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg   <= '0;
            header_index_reg <= '0;
            field_shift_reg  <= '0;
            seg_command_reg  <= '0;
            seg_window_reg   <= '0;
            payload_left_reg <= '0;
            in_payload_reg   <= 1'b0;
            pushes_seen_reg  <= '0;
            bad_packet_reg   <= 1'b0;
        end
        else if (step)
        begin
            if (last_byte)
            begin
                // start clean for the next datagram
                byte_count_reg   <= '0;
                header_index_reg <= '0;
                field_shift_reg  <= '0;
                seg_command_reg  <= '0;
                seg_window_reg   <= '0;
                payload_left_reg <= '0;
                in_payload_reg   <= 1'b0;
                pushes_seen_reg  <= '0;
                bad_packet_reg   <= 1'b0;
            end
            else
            begin
                byte_count_reg   <= byte_count_next;
                header_index_reg <= header_index_next;
                field_shift_reg  <= field_shift_next;
                seg_command_reg  <= seg_command_next;
                seg_window_reg   <= seg_window_next;
                payload_left_reg <= payload_left_next;
                in_payload_reg   <= in_payload_next;
                pushes_seen_reg  <= pushes_seen_next;
                bad_packet_reg   <= bad_packet_next;
            end
        end
    end

endmodule

### src/kcp_packet_validator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcp_packet_validator
// Byte-stream checker for datagrams made of back-to-back KCP segments.
// ----------------------------------------------------------------------------
// Takes one datagram byte per cycle while not stalled and gives one verdict
// item on the byte marked tlast. Each byte updates the header walker in the
// cycle it is accepted, so a new byte is taken every clock unless a last byte
// waits for room; the verdict sits in an output register, and the input keeps
// flowing while it is unclaimed unless a second verdict would overwrite it.
// The verdict appears in the cycle after the last byte is accepted.
// Configuration writes must happen while no packet is in flight.
module kcp_packet_validator (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // byte stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] data_byte, [8] channel_failed, [24:9] pending_acks, [31:25] zero
    input  logic [31:0] s_axis_tdata,
    input  logic        s_axis_tlast,     // last_byte
    // verdict out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] accept, [7:1] push_count
    output logic [7:0]  m_axis_tdata
);
    import kcpv_pkg::*;

    cfg_t     cfg_reg;
    verdict_t verdict;
    verdict_t out_reg;
    logic     out_valid_reg;
    logic     step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.conversation_id   <= '0;
            cfg_reg.max_peer_window   <= RST_MAX_WINDOW;
            cfg_reg.max_payload_bytes <= RST_MAX_PAYLOAD;
            cfg_reg.max_packet_bytes  <= RST_MAX_PACKET;
            cfg_reg.ack_limit         <= RST_MAX_PENDING;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CONV_ID:     cfg_reg.conversation_id   <= cfg_data;
                REG_MAX_WINDOW:  cfg_reg.max_peer_window   <= cfg_data[15:0];
                REG_MAX_PAYLOAD: cfg_reg.max_payload_bytes <= cfg_data[15:0];
                REG_MAX_PACKET:  cfg_reg.max_packet_bytes  <= cfg_data[COUNT_W-1:0];
                REG_MAX_PENDING: cfg_reg.ack_limit         <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // only a last byte produces a verdict, so only it must wait for room
    assign s_axis_tready = !s_axis_tlast || !out_valid_reg || m_axis_tready;
    assign step          = s_axis_tvalid && s_axis_tready;

    kcpv_parser u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .step           (step),
        .data_byte      (s_axis_tdata[7:0]),
        .last_byte      (s_axis_tlast),
        .channel_failed (s_axis_tdata[8]),
        .pending_acks   (s_axis_tdata[24:9]),
        .verdict        (verdict)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step && s_axis_tlast)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step && s_axis_tlast)
            out_reg <= verdict;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.push_count, out_reg.accept};

endmodule
